[src/pse_pkg.sv]
// shared types and codes of the postfix stack evaluator
package pse_pkg;

  localparam int WORD_W = 64;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_OP     = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // operator codes
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_REM = 4'd4;
  localparam logic [3:0] OP_SHL = 4'd5;
  localparam logic [3:0] OP_SHR = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_XOR = 4'd8;
  localparam logic [3:0] OP_OR  = 4'd9;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_UNDER    = 3'd1;
  localparam logic [2:0] STAT_DIVZERO  = 3'd2;
  localparam logic [2:0] STAT_BADOP    = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW = 3'd4;
  localparam logic [2:0] STAT_LEFTOVER = 3'd5;

  // configuration register indexes
  localparam logic REG_ZERO_DIV_MODE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
    logic mul_start;
    logic div_start;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic mul_done;
    logic div_done;
  } dp_status_t;

endpackage

[src/pse_ctrl.sv]
// controller state machine of the postfix stack evaluator
module pse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pse_pkg::dp_status_t stat,
  output pse_pkg::ctrl_cmd_t  ctl
);
  import pse_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.need_mul) state_next = S_MUL;
        else if (stat.need_div) state_next = S_DIV;
        else if (out_free) state_next = S_IDLE;
      end
      S_MUL: begin
        if (stat.mul_done) state_next = S_COMMIT;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl = '0;
    unique case (state) inside
      S_IDLE: begin
        ctl.accept = in_valid;
      end
      S_EXEC: begin
        ctl.mul_start = stat.need_mul;
        ctl.div_start = stat.need_div && !stat.need_mul;
        ctl.commit    = !stat.need_mul && !stat.need_div && out_free;
      end
      S_COMMIT: begin
        ctl.commit = out_free;
      end
      S_MUL, S_DIV: begin
        ctl = '0;
      end
      default: ctl = '0;
    endcase
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // a result never overwrites a word still waiting at the output
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!out_valid || !out_stall))
    else $error("commit while output word is held");

  // multiplier finishes only while the controller waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> (state == S_MUL))
    else $error("multiplier done outside wait state");

  // divider finishes only while the controller waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DIV))
    else $error("divider done outside wait state");
`endif

endmodule

[src/pse_mul.sv]
// multi-cycle 64-bit multiplier built from one 32x32 partial product a cycle
module pse_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] product
);
  import pse_pkg::*;

  logic        busy;
  logic [1:0]  cnt;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;
  logic [63:0] acc;

  assign done    = busy && (cnt == 2'd3);
  assign product = acc;

  // partial product operand select
  always_comb begin
    case (cnt)
      2'd0: begin
        mx = opa[31:0];
        my = opb[31:0];
      end
      2'd1: begin
        mx = opa[31:0];
        my = opb[WORD_W-1:32];
      end
      2'd2: begin
        mx = opa[WORD_W-1:32];
        my = opb[31:0];
      end
      default: begin
        mx = opa[31:0];
        my = opb[31:0];
      end
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) busy <= 1'b0;
    end
  end

  // product register and accumulation of the previous step
  always_ff @(posedge clk) begin
    if (busy) begin
      prod <= {32'd0, mx} * {32'd0, my};
      if (cnt == 2'd1) begin
        acc <= prod;
      end else if (cnt != 2'd0) begin
        acc[WORD_W-1:32] <= acc[WORD_W-1:32] + prod[31:0];
      end
    end
  end

endmodule

[src/pse_div.sv]
// iterative signed divider, one quotient bit a cycle
module pse_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  import pse_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign done      = busy && (cnt == 6'd63);
  assign shifted   = {rem, quo[WORD_W-1]};
  assign diff      = shifted - {1'b0, dsr};
  assign quotient  = neg_q ? (64'd0 - quo) : quo;
  assign remainder = neg_r ? (64'd0 - rem) : rem;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) busy <= 1'b0;
    end
  end

  // restoring shift-subtract on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[WORD_W-1] ? (64'd0 - dividend) : dividend;
      dsr   <= divisor[WORD_W-1] ? (64'd0 - divisor) : divisor;
      rem   <= 64'd0;
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

[src/pse_datapath.sv]
// operand stack, top register, arithmetic units and output word register
module pse_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  pse_pkg::ctrl_cmd_t  ctl,
  output pse_pkg::dp_status_t stat,
  input  logic               zero_div_mode,
  input  logic [1:0]         cmd,
  input  logic signed [63:0] number_value,
  input  logic [3:0]         operator_code,
  output logic [2:0]         status,
  output logic signed [63:0] result_value,
  output logic [6:0]         stack_depth,
  output logic               is_final
);
  import pse_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
  localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);

  logic [63:0]     stack_mem [STACK_DEPTH];
  logic [63:0]     rd_data;
  logic [SP_W-1:0] sp;
  logic [63:0]     tos;
  logic [1:0]      cmd_q;
  logic [63:0]     num_q;
  logic [3:0]      op_q;

  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;
  logic [63:0]     lhs;
  logic [63:0]     rhs;
  logic [63:0]     divisor;
  logic            rhs_zero;
  logic            is_divop;
  logic [63:0]     simple_res;
  logic [63:0]     alu_res;
  logic [63:0]     mul_res;
  logic [63:0]     quo_res;
  logic [63:0]     rem_res;
  logic            mul_done;
  logic            div_done;

  logic [2:0]      sp_status;
  logic [63:0]     sp_value;
  logic [SP_W-1:0] sp_new;
  logic            sp_fin;
  logic            mem_we;
  logic            tos_load;
  logic [SP_W+6:0] depth_ext;

  assign sp_m1    = sp - SP_ONE;
  assign sp_m2    = sp - SP_TWO;
  assign lhs      = rd_data;
  assign rhs      = tos;
  assign rhs_zero = (rhs == 64'd0);
  assign is_divop = (op_q == OP_DIV) || (op_q == OP_REM);
  assign divisor  = rhs_zero ? 64'd1 : rhs;

  // latched item and stack read of the second entry
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q   <= cmd;
      num_q   <= number_value;
      op_q    <= operator_code;
      rd_data <= stack_mem[sp_m2[AW-1:0]];
    end
  end

  // stack write of the old top on a push
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[sp_m1[AW-1:0]] <= tos;
    end
  end

  // combinational operators
  always_comb begin
    case (op_q)
      OP_ADD:  simple_res = lhs + rhs;
      OP_SUB:  simple_res = lhs - rhs;
      OP_SHL:  simple_res = lhs << rhs[5:0];
      OP_SHR:  simple_res = $unsigned($signed(lhs) >>> rhs[5:0]);
      OP_AND:  simple_res = lhs & rhs;
      OP_XOR:  simple_res = lhs ^ rhs;
      default: simple_res = lhs | rhs;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_MUL:  alu_res = mul_res;
      OP_DIV:  alu_res = quo_res;
      OP_REM:  alu_res = rem_res;
      default: alu_res = simple_res;
    endcase
  end

  pse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.mul_start),
    .opa     (lhs),
    .opb     (rhs),
    .done    (mul_done),
    .product (mul_res)
  );

  pse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (lhs),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quo_res),
    .remainder (rem_res)
  );

  // long operations needed by the latched item
  always_comb begin
    stat          = '0;
    stat.need_mul = (cmd_q == CMD_OP) && (sp >= SP_TWO) && (op_q == OP_MUL);
    stat.need_div = (cmd_q == CMD_OP) && (sp >= SP_TWO) && is_divop &&
                    !(rhs_zero && !zero_div_mode);
    stat.mul_done = mul_done;
    stat.div_done = div_done;
  end

  // stack update and result word of the latched item
  always_comb begin
    sp_status = STAT_OK;
    sp_value  = 64'd0;
    sp_new    = '0;
    sp_fin    = 1'b0;
    mem_we    = 1'b0;
    tos_load  = 1'b0;
    case (cmd_q)
      CMD_PUSH: begin
        if (sp >= SP_FULL) begin
          sp_status = STAT_OVERFLOW;
        end else begin
          sp_value = num_q;
          sp_new   = sp + SP_ONE;
          tos_load = ctl.commit;
          mem_we   = ctl.commit && (sp != '0);
        end
      end
      CMD_OP: begin
        if (sp < SP_TWO) begin
          sp_status = STAT_UNDER;
        end else if (op_q > OP_OR) begin
          sp_status = STAT_BADOP;
        end else if (is_divop && rhs_zero && !zero_div_mode) begin
          sp_status = STAT_DIVZERO;
        end else begin
          sp_value = alu_res;
          sp_new   = sp_m1;
          tos_load = ctl.commit;
        end
      end
      CMD_FINISH: begin
        sp_fin = 1'b1;
        if (sp == '0) begin
          sp_status = STAT_UNDER;
        end else if (sp != SP_ONE) begin
          sp_status = STAT_LEFTOVER;
        end else begin
          sp_value = tos;
        end
      end
      default: begin
        sp_new   = sp;
        sp_value = (sp != '0) ? tos : 64'd0;
      end
    endcase
  end

  assign depth_ext = {7'd0, sp_new};

  // stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.commit) begin
      sp <= sp_new;
    end
  end

  // top of stack
  always_ff @(posedge clk) begin
    if (tos_load) begin
      tos <= sp_value;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status       <= sp_status;
      result_value <= sp_value;
      stack_depth  <= depth_ext[6:0];
      is_final     <= sp_fin;
    end
  end

endmodule

[src/postfix_stack_evaluator.sv]
// top level of the postfix stack evaluator
//
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | cmd, number_value, operator_code
//  output   | out_valid / out_stall| status, result_value, stack_depth, is_final
//  config   | apb psel / penable   | zero_divisor_mode at byte address 0
//
// push, finish and the combinational operators pass through accept, then execute.
// multiply forms three 32x32 partial products through one multiplier.
// divide and remainder run in the divider, which retires one quotient bit a cycle.
// reset clears the stack pointer and the output valid; stack memory is not cleared.
// a word held by out_stall stays in the output register; the next word is accepted
// and waits in execute or commit until the output register frees.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [63:0] number_value,
  input  logic [3:0]         operator_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [63:0] result_value,
  output logic [6:0]         stack_depth,
  output logic               is_final,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pse_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t stat;
  logic       zero_div_mode;

  assign pready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_div_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_ZERO_DIV_MODE)) begin
      zero_div_mode <= pwdata[0];
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_ZERO_DIV_MODE: prdata = {31'd0, zero_div_mode};
      default:           prdata = 32'd0;
    endcase
  end

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .zero_div_mode (zero_div_mode),
    .cmd           (cmd),
    .number_value  (number_value),
    .operator_code (operator_code),
    .status        (status),
    .result_value  (result_value),
    .stack_depth   (stack_depth),
    .is_final      (is_final)
  );

endmodule
